>>> rtl/process_table_priority_scheduler_unit_macros.svh
// Assertion macros for the process table scheduler.
`ifndef PROCESS_TABLE_PRIORITY_SCHEDULER_UNIT_MACROS_SVH
`define PROCESS_TABLE_PRIORITY_SCHEDULER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define PTS_ASSERT_IMPL(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");
`define PTS_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");
`else
`define PTS_ASSERT_IMPL(label, clk_s, rst_s, ante, cons)
`define PTS_ASSERT_NEXT(label, clk_s, rst_s, ante, cons)
`endif
`endif

>>> rtl/pts_pkg.sv
// Shared types and constants for the process table scheduler.
package pts_pkg;

  localparam int PICK_W = 8;

  localparam logic [2:0] OP_SLEEP     = 3'd0;
  localparam logic [2:0] OP_WAKEUP    = 3'd1;
  localparam logic [2:0] OP_SET_PRIO  = 3'd2;
  localparam logic [2:0] OP_SELECT    = 3'd3;
  localparam logic [2:0] OP_SET_SLOT  = 3'd4;
  localparam logic [2:0] OP_SWAP_WAIT = 3'd5;

  localparam logic [2:0] ST_SLEEP = 3'd1;
  localparam logic [2:0] ST_WAIT  = 3'd2;
  localparam logic [2:0] ST_RUN   = 3'd3;

  localparam logic [6:0] BASE_RESET = 7'd100;
  localparam logic [7:0] PRIO_IDLE  = 8'd127;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

  // scan token handed from cell to cell
  typedef struct packed {
    logic              vld;
    logic [8:0]        best;
    logic [PICK_W-1:0] pick;
    logic              any;
    logic              sw;
    logic              swq;
    logic              rs;
  } carry_t;

  typedef struct packed {
    logic        wr_chan;
    logic        wr_prio;
    logic        wr_status;
    logic        wr_res;
    logic [15:0] chan;
    logic [7:0]  prio;
    logic [2:0]  status;
    logic        loaded;
    logic        wake;
    logic        sel;
    logic        kill;
    logic [7:0]  cur;
  } cell_cmd_t;

endpackage

>>> rtl/pts_cell.sv
// One process table slot with its link in the scan chain.
module pts_cell
  import pts_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  cell_cmd_t cmd,
  input  logic      hit,
  input  logic      inject,
  input  carry_t    init,
  input  carry_t    prev,
  output carry_t    cout
);

  logic [2:0]  st;
  logic        res;
  logic [7:0]  prio;
  logic [15:0] ch;
  carry_t      cin;
  carry_t      o;
  logic        act;
  logic        woke;

  always_comb begin
    cin  = inject ? init : prev;
    act  = cin.vld && !cmd.kill;
    woke = act && cmd.wake && (ch == cmd.chan);
    o    = cin;
    if (woke) begin
      if ($signed(prio) < $signed(cmd.cur)) o.rs = 1'b1;
      if (cin.sw && !res) begin
        o.sw  = 1'b0;
        o.swq = 1'b1;
      end
    end
    if (act && cmd.sel && st == ST_RUN && res &&
        $signed({prio[7], prio}) < $signed(cin.best)) begin
      o.best = {prio[7], prio};
      o.pick = PICK_W'(IDX);
      o.any  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= '0;
      res  <= 1'b0;
      prio <= '0;
      ch   <= '0;
      cout <= '0;
    end else begin
      cout <= o;
      if (cmd.kill) cout.vld <= 1'b0;
      if (woke) begin
        ch <= '0;
        st <= ST_RUN;
      end
      if (hit && cmd.wr_chan) ch <= cmd.chan;
      if (hit && cmd.wr_prio) prio <= cmd.prio;
      if (hit && cmd.wr_status) st <= cmd.status;
      if (hit && cmd.wr_res) res <= cmd.loaded;
    end
  end

endmodule

>>> rtl/pts_cell_row.sv
// Ring of slot cells; the scan token moves one cell per cycle.
module pts_cell_row
  import pts_pkg::*;
#(
  parameter int SLOTS = 64,
  parameter int IW    = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  cell_cmd_t     cmd,
  input  logic [IW-1:0] addr,
  input  logic          inject,
  input  logic [IW-1:0] start_idx,
  input  carry_t        init,
  input  logic [IW-1:0] end_idx,
  output carry_t        result
);

  carry_t carry [SLOTS];

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    localparam int PREV = (i == 0) ? SLOTS - 1 : i - 1;
    pts_cell #(.IDX(i)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .cmd    (cmd),
      .hit    (addr == IW'(i)),
      .inject (inject && start_idx == IW'(i)),
      .init   (init),
      .prev   (carry[PREV]),
      .cout   (carry[i])
    );
  end

  assign result = carry[end_idx];

endmodule

>>> rtl/process_table_priority_scheduler_unit.sv
// Process table scheduler top level: control, flags and result registers.
// Sleep, set priority, set slot, swapper wait and wakeup on channel 0 give their
// result in the cycle after the transfer; wakeup and select scan through S_SCAN and S_DONE.
// A new item is taken only while idle; the scan token walks the cell ring.
// Reset (rst, synchronous): all slots free, current priority 127, base 100.
// Results show for one cycle with done; the receiver cannot stall.
`include "process_table_priority_scheduler_unit_macros.svh"
module process_table_priority_scheduler_unit
  import pts_pkg::*;
#(
  parameter int SLOTS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              cfg_we,
  input  logic [6:0]        cfg_wdata,
  input  logic [2:0]        operation,
  input  logic [5:0]        slot,
  input  logic [15:0]       channel,
  input  logic signed [7:0] priority_req,
  input  logic [2:0]        status,
  input  logic              loaded,
  input  logic [7:0]        cpu_usage,
  input  logic signed [5:0] nice,
  output logic              done,
  output logic [5:0]        selected_slot,
  output logic              found,
  output logic              reschedule,
  output logic              swap_in_request
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  state_t        state, state_next;
  logic [6:0]    user_base;
  logic [7:0]    current_priority;
  logic          resched_flag;
  logic [IW-1:0] last_selected;
  logic          swapper_waiting;
  logic [IW-1:0] cnt;
  logic [IW-1:0] end_idx;
  logic [15:0]   chan_q;
  logic          scan_sel;

  logic          accept;
  logic          slot_ok;
  logic [IW+5:0] slot_ext;
  logic [IW-1:0] addr;
  logic          scan_go;
  logic [IW-1:0] sel_start;
  logic [IW-1:0] start_idx;
  logic signed [9:0] p_sum;
  logic signed [9:0] p_clip;
  logic          flag_next;
  logic          kill;
  cell_cmd_t     cmd;
  carry_t        init;
  carry_t        res;
  logic [IW+5:0] pick_ext;

  assign accept   = start && !busy;
  assign slot_ext = (IW + 6)'(slot);
  assign slot_ok  = slot_ext < (IW + 6)'(SLOTS);
  assign addr     = slot_ext[IW-1:0];
  assign scan_go  = operation == OP_SELECT || (operation == OP_WAKEUP && channel != '0);
  assign sel_start = (last_selected == IW'(SLOTS - 1)) ? '0 : last_selected + 1'b1;
  assign start_idx = (operation == OP_SELECT) ? sel_start : '0;

  always_comb begin
    p_sum  = $signed({6'b0, cpu_usage[7:4]}) + $signed({3'b0, user_base}) +
             10'(nice);
    p_clip = (p_sum > 10'sd127) ? 10'sd127 : p_sum;
    flag_next = resched_flag;
    if (operation == OP_SET_PRIO && slot_ok &&
        p_clip < $signed({{2{current_priority[7]}}, current_priority}))
      flag_next = 1'b1;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept && scan_go) state_next = S_SCAN;
      S_SCAN: if (cnt == IW'(SLOTS - 2)) state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy = 1'b0;
    kill = 1'b0;
    unique case (state)
      S_IDLE: ;
      S_SCAN: busy = 1'b1;
      S_DONE: begin
        busy = 1'b1;
        kill = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.wr_chan   = accept && slot_ok && operation == OP_SLEEP;
    cmd.wr_prio   = accept && slot_ok &&
                    (operation == OP_SLEEP || operation == OP_SET_PRIO);
    cmd.wr_status = accept && slot_ok &&
                    (operation == OP_SLEEP || operation == OP_SET_SLOT);
    cmd.wr_res    = accept && slot_ok && operation == OP_SET_SLOT;
    cmd.chan      = busy ? chan_q : channel;
    cmd.prio      = (operation == OP_SLEEP) ? priority_req : p_clip[7:0];
    if (operation == OP_SLEEP)
      cmd.status  = priority_req[7] ? ST_SLEEP : ST_WAIT;
    else
      cmd.status  = status;
    cmd.loaded    = loaded;
    cmd.wake      = busy ? !scan_sel : (operation == OP_WAKEUP);
    cmd.sel       = busy ? scan_sel : (operation == OP_SELECT);
    cmd.kill      = kill;
    cmd.cur       = current_priority;
  end

  always_comb begin
    init      = '0;
    init.vld  = 1'b1;
    init.best = 9'd128;
    init.sw   = swapper_waiting;
  end

  pts_cell_row #(.SLOTS(SLOTS), .IW(IW)) u_row (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .addr      (addr),
    .inject    (accept && scan_go),
    .start_idx (start_idx),
    .init      (init),
    .end_idx   (end_idx),
    .result    (res)
  );

  assign pick_ext = (IW + 6)'(res.pick[IW-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      user_base        <= BASE_RESET;
      current_priority <= PRIO_IDLE;
      resched_flag     <= 1'b0;
      last_selected    <= '0;
      swapper_waiting  <= 1'b0;
      cnt              <= '0;
      done             <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (cfg_we) user_base <= cfg_wdata;
      if (state == S_SCAN) cnt <= cnt + 1'b1;
      if (accept) begin
        cnt      <= '0;
        chan_q   <= channel;
        scan_sel <= operation == OP_SELECT;
        end_idx  <= (operation == OP_SELECT) ? last_selected : IW'(SLOTS - 1);
        if (!scan_go) begin
          done            <= 1'b1;
          selected_slot   <= '0;
          found           <= 1'b0;
          reschedule      <= flag_next;
          swap_in_request <= 1'b0;
          resched_flag    <= flag_next;
          if (operation == OP_SWAP_WAIT) swapper_waiting <= 1'b1;
        end
      end
      if (state == S_DONE) begin
        done <= 1'b1;
        if (scan_sel) begin
          resched_flag    <= 1'b0;
          reschedule      <= 1'b0;
          swap_in_request <= 1'b0;
          found           <= res.any;
          selected_slot   <= res.any ? pick_ext[5:0] : '0;
          if (res.any) begin
            last_selected    <= res.pick[IW-1:0];
            current_priority <= res.best[7:0];
          end
        end else begin
          resched_flag    <= resched_flag | res.rs;
          reschedule      <= resched_flag | res.rs;
          swapper_waiting <= res.sw;
          swap_in_request <= res.swq;
          found           <= 1'b0;
          selected_slot   <= '0;
        end
      end
    end
  end

  `PTS_ASSERT_NEXT(a_done_after_scan, clk, rst, state == S_DONE, done)
  `PTS_ASSERT_NEXT(a_quick_op_done, clk, rst, accept && !scan_go, done && !busy)
  `PTS_ASSERT_IMPL(a_swap_clears_wait, clk, rst, done && swap_in_request, !swapper_waiting)
  `PTS_ASSERT_IMPL(a_found_only_select, clk, rst, done && found, !reschedule && !swap_in_request)

endmodule
